// ===== rtl/iopt_pkg.sv =====
// ----------------------------------------------------------------------------
// iopt_pkg
// Shared constants, state encoding and control bundles for the interval
// overlap peak tracker.
// ----------------------------------------------------------------------------
package iopt_pkg;

  localparam int unsigned TIME_SLOTS_DEF = 1024;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned IN_START_W  = 10;
  localparam int unsigned IN_END_W    = 11;
  localparam int unsigned OUT_PEAK_W  = 16;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_LAT,
    S_EVAL,
    S_RET,
    S_DONE
  } iopt_state_t;

  typedef struct packed {
    logic clr;
    logic start;
    logic rd;
    logic lat;
    logic eval;
    logic go_right;
    logic pop;
    logic load_out;
  } iopt_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic partial;
    logic at_root;
    logic right_phase;
    logic out_free;
  } iopt_stat_t;

endpackage

// ===== rtl/iopt_ram.sv =====
// ----------------------------------------------------------------------------
// iopt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module iopt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/iopt_ctrl.sv =====
// ----------------------------------------------------------------------------
// iopt_ctrl
// Sequencer for the segment tree walk: clear pass, node read/evaluate,
// descent, return and result hand-off.
// ----------------------------------------------------------------------------
module iopt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  iopt_pkg::iopt_stat_t st,
  output iopt_pkg::iopt_cmd_t  cmd
);
  import iopt_pkg::*;

  iopt_state_t state_r;
  iopt_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LAT;
      end
      S_LAT: begin
        cmd.lat   = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = st.partial ? S_RD : S_RET;
      end
      S_RET: begin
        priority if (st.at_root) begin
          state_nxt = S_DONE;
        end else if (st.right_phase) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.go_right = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_no_reclear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR) |=> (state_r != S_CLEAR))
    else $error("clear pass re-entered");

  a_idle_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> st.at_root)
    else $error("idle with tree walk unfinished");

  a_done_from_root: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && ($past(state_r) == S_RET)) |-> $past(st.at_root))
    else $error("result taken below the root");

endmodule

// ===== rtl/iopt_dp.sv =====
// ----------------------------------------------------------------------------
// iopt_dp
// Segment tree datapath: node stores, current node, return stack,
// saturating adds and the output register.
// ----------------------------------------------------------------------------
module iopt_dp #(
  parameter int unsigned TIME_SLOTS = iopt_pkg::TIME_SLOTS_DEF,
  parameter int unsigned COUNT_BITS = iopt_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [iopt_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  iopt_pkg::iopt_cmd_t                cmd,
  output iopt_pkg::iopt_stat_t               st,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [iopt_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import iopt_pkg::*;

  localparam int unsigned NODE_COUNT = 2 * TIME_SLOTS;
  localparam int unsigned ADDR_W     = $clog2(NODE_COUNT);
  localparam int unsigned SLOT_W     = $clog2(TIME_SLOTS + 1);
  localparam int unsigned CMP_W      = (SLOT_W > IN_END_W) ? SLOT_W : IN_END_W;
  localparam int unsigned TREE_H     = $clog2(TIME_SLOTS);
  localparam int unsigned LVL_W      = $clog2(TREE_H + 1);
  localparam int unsigned STK_W      = (TREE_H > 1) ? $clog2(TREE_H) : 1;

  logic [IN_START_W-1:0] in_start;
  logic [IN_END_W-1:0]   in_end;
  logic [CMP_W-1:0]      s_x, e_x, t_x, e_clip;

  logic [CMP_W-1:0]      s_r, s_nxt, e_r, e_nxt;
  logic                  empty_r, empty_nxt;
  logic [ADDR_W-1:0]     cur_idx_r, cur_idx_nxt;
  logic [SLOT_W-1:0]     cur_lo_r, cur_lo_nxt, cur_hi_r, cur_hi_nxt;
  logic [COUNT_BITS-1:0] cur_c_r, cur_c_nxt;
  logic [LVL_W-1:0]      level_r, level_nxt, lvl_m1;
  logic [COUNT_BITS-1:0] pend_eff_r, pend_eff_nxt, peak_q_r, peak_q_nxt;
  logic [COUNT_BITS-1:0] ret_r, ret_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_PEAK_W-1:0] out_data_r, out_data_nxt;

  logic [ADDR_W-1:0]     stk_idx_r [TREE_H];
  logic [ADDR_W-1:0]     stk_rc_r  [TREE_H];
  logic [SLOT_W-1:0]     stk_mid_r [TREE_H];
  logic [SLOT_W-1:0]     stk_hi_r  [TREE_H];
  logic [COUNT_BITS-1:0] stk_c_r   [TREE_H];
  logic [COUNT_BITS-1:0] stk_lv_r  [TREE_H];
  logic [TREE_H-1:0]     stk_ph_r;
  logic [STK_W-1:0]      push_ix, top_ix;

  logic [COUNT_BITS-1:0] pend_rd, peak_rd;
  logic [CMP_W-1:0]      lo_x, hi_x;
  logic                  disj, cov, partial;
  logic [SLOT_W:0]       lohi_sum;
  logic [SLOT_W-1:0]     mid, half;
  logic [ADDR_W-1:0]     lc, rc;
  logic [COUNT_BITS:0]   pend_in_sum, val_sum;
  logic [COUNT_BITS-1:0] pend_in, p1, node_add, node_val, pend_wr;
  logic [COUNT_BITS-1:0] top_lv, pop_max;
  logic [OUT_PEAK_W-1:0] out_clamp;

  logic                  pend_we, peak_we;
  logic [ADDR_W-1:0]     pend_waddr, peak_waddr;
  logic [COUNT_BITS-1:0] pend_wdata, peak_wdata;

  // input unpack and end clipping
  assign in_start = in_tdata[IN_START_W-1:0];
  assign in_end   = in_tdata[IN_START_W +: IN_END_W];
  assign s_x      = CMP_W'(in_start);
  assign e_x      = CMP_W'(in_end);
  assign t_x      = CMP_W'(TIME_SLOTS);
  assign e_clip   = (e_x > t_x) ? t_x : e_x;

  // node classification and child addresses
  assign lo_x     = CMP_W'(cur_lo_r);
  assign hi_x     = CMP_W'(cur_hi_r);
  assign disj     = empty_r | (hi_x <= s_r) | (lo_x >= e_r);
  assign cov      = (s_r <= lo_x) & (hi_x <= e_r);
  assign partial  = ~disj & ~cov;
  assign lohi_sum = {1'b0, cur_lo_r} + {1'b0, cur_hi_r};
  assign mid      = lohi_sum[SLOT_W:1];
  assign half     = mid - cur_lo_r;
  assign lc       = cur_idx_r + ADDR_W'(1);
  assign rc       = cur_idx_r + (ADDR_W'(half) << 1);

  // saturating adds
  assign pend_in_sum = {1'b0, pend_rd} + {1'b0, cur_c_r};
  assign pend_in     = pend_in_sum[COUNT_BITS] ? '1 : pend_in_sum[COUNT_BITS-1:0];
  assign p1          = (&pend_eff_r) ? pend_eff_r : pend_eff_r + COUNT_BITS'(1);
  assign node_add    = cov ? p1 : pend_eff_r;
  assign val_sum     = {1'b0, peak_q_r} + {1'b0, node_add};
  assign node_val    = val_sum[COUNT_BITS] ? '1 : val_sum[COUNT_BITS-1:0];
  assign pend_wr     = disj ? pend_eff_r : (cov ? p1 : '0);

  // return stack
  assign lvl_m1  = level_r - LVL_W'(1);
  assign push_ix = level_r[STK_W-1:0];
  assign top_ix  = lvl_m1[STK_W-1:0];
  assign top_lv  = stk_lv_r[top_ix];
  assign pop_max = (top_lv > ret_r) ? top_lv : ret_r;

  generate
    if (COUNT_BITS > OUT_PEAK_W) begin : g_clamp
      assign out_clamp = (|ret_r[COUNT_BITS-1:OUT_PEAK_W]) ? '1 : ret_r[OUT_PEAK_W-1:0];
    end else begin : g_extend
      assign out_clamp = OUT_PEAK_W'(ret_r);
    end
  endgenerate

  always_comb begin
    s_nxt         = s_r;
    e_nxt         = e_r;
    empty_nxt     = empty_r;
    cur_idx_nxt   = cur_idx_r;
    cur_lo_nxt    = cur_lo_r;
    cur_hi_nxt    = cur_hi_r;
    cur_c_nxt     = cur_c_r;
    level_nxt     = level_r;
    pend_eff_nxt  = pend_eff_r;
    peak_q_nxt    = peak_q_r;
    ret_nxt       = ret_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cmd.clr) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
    end
    if (cmd.start) begin
      s_nxt       = s_x;
      e_nxt       = e_clip;
      empty_nxt   = (s_x >= e_clip);
      cur_idx_nxt = '0;
      cur_lo_nxt  = '0;
      cur_hi_nxt  = SLOT_W'(TIME_SLOTS);
      cur_c_nxt   = '0;
      level_nxt   = '0;
    end
    if (cmd.lat) begin
      pend_eff_nxt = pend_in;
      peak_q_nxt   = peak_rd;
    end
    if (cmd.eval) begin
      if (partial) begin
        cur_idx_nxt = lc;
        cur_hi_nxt  = mid;
        cur_c_nxt   = pend_eff_r;
        level_nxt   = level_r + LVL_W'(1);
      end else begin
        ret_nxt = node_val;
      end
    end
    if (cmd.go_right) begin
      cur_idx_nxt = stk_rc_r[top_ix];
      cur_lo_nxt  = stk_mid_r[top_ix];
      cur_hi_nxt  = stk_hi_r[top_ix];
      cur_c_nxt   = stk_c_r[top_ix];
    end
    if (cmd.pop) begin
      ret_nxt   = pop_max;
      level_nxt = lvl_m1;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = out_clamp;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      level_r     <= level_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    empty_r    <= empty_nxt;
    cur_idx_r  <= cur_idx_nxt;
    cur_lo_r   <= cur_lo_nxt;
    cur_hi_r   <= cur_hi_nxt;
    cur_c_r    <= cur_c_nxt;
    pend_eff_r <= pend_eff_nxt;
    peak_q_r   <= peak_q_nxt;
    ret_r      <= ret_nxt;
    out_data_r <= out_data_nxt;
  end

  // frame pushed on a split, left peak parked before the right descent
  always_ff @(posedge clk) begin
    if (cmd.eval && partial) begin
      stk_idx_r[push_ix] <= cur_idx_r;
      stk_rc_r[push_ix]  <= rc;
      stk_mid_r[push_ix] <= mid;
      stk_hi_r[push_ix]  <= cur_hi_r;
      stk_c_r[push_ix]   <= pend_eff_r;
      stk_ph_r[push_ix]  <= 1'b0;
    end
    if (cmd.go_right) begin
      stk_lv_r[top_ix] <= ret_r;
      stk_ph_r[top_ix] <= 1'b1;
    end
  end

  // pending add is pushed lazily: a child takes its parent's owed add on visit
  assign pend_we    = cmd.clr | cmd.eval;
  assign pend_waddr = cmd.clr ? clr_addr_r : cur_idx_r;
  assign pend_wdata = cmd.clr ? '0 : pend_wr;
  assign peak_we    = cmd.clr | cmd.pop;
  assign peak_waddr = cmd.clr ? clr_addr_r : stk_idx_r[top_ix];
  assign peak_wdata = cmd.clr ? '0 : pop_max;

  iopt_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NODE_COUNT)
  ) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .raddr (cur_idx_r),
    .rdata (pend_rd)
  );

  iopt_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NODE_COUNT)
  ) u_peak_ram (
    .clk   (clk),
    .we    (peak_we),
    .waddr (peak_waddr),
    .wdata (peak_wdata),
    .raddr (cur_idx_r),
    .rdata (peak_rd)
  );

  assign st.clear_last  = (clr_addr_r == ADDR_W'(NODE_COUNT - 1));
  assign st.partial     = partial;
  assign st.at_root     = (level_r == '0);
  assign st.right_phase = stk_ph_r[top_ix];
  assign st.out_free    = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(TREE_H))
    else $error("return stack overflow");

  a_split_width: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && partial) |-> ((cur_hi_r - cur_lo_r) >= SLOT_W'(2)))
    else $error("split of a single-slot node");

  a_node_span: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (cur_lo_r < cur_hi_r))
    else $error("node with empty span visited");

  a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (level_r != '0))
    else $error("pop at the root");

endmodule

// ===== rtl/interval_overlap_peak_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// interval_overlap_peak_tracker_unit
// Books half-open slot intervals into a range-add / range-max segment tree
// and returns the peak slot occupancy after each booking.
// ----------------------------------------------------------------------------
//  channel | dir | tdata bits (low to high)
//  in_     | in  | range_start[9:0], range_end[20:10], zero pad [23:21]
//  out_    | out | peak_overlap[15:0]
//
//  Per item: each tree node visited passes through RAM read, latch and
//  evaluate states; each split node is revisited on the way back, to turn
//  right and then to pop. The registered node-store read needs the latch step.
//  After reset a clearing pass zeroes the node stores;
//  no item is taken until it ends. A stalled result waits in the output
//  register; the next item is taken and walked meanwhile.
// ----------------------------------------------------------------------------
module interval_overlap_peak_tracker_unit #(
  parameter int unsigned TIME_SLOTS = iopt_pkg::TIME_SLOTS_DEF,
  parameter int unsigned COUNT_BITS = iopt_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [iopt_pkg::IN_TDATA_W-1:0]  in_tdata,   // range_start, range_end
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [iopt_pkg::OUT_TDATA_W-1:0] out_tdata   // peak_overlap
);
  import iopt_pkg::*;

  iopt_cmd_t  cmd;
  iopt_stat_t st;

  iopt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  iopt_dp #(
    .TIME_SLOTS (TIME_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== verif/interval_overlap_peak_tracker_unit_test.sv =====
// ----------------------------------------------------------------------------
// interval_overlap_peak_tracker_unit_test
// Books slot intervals into the peak tracker and checks each returned peak
// against a flat per-slot occupancy predictor with saturating counts.
// Covers full, single-slot, clipped and empty bookings, then random ones,
// with random idle gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module interval_overlap_peak_tracker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import iopt_pkg::*;

  localparam int unsigned SLOTS           = TIME_SLOTS_DEF;
  localparam longint unsigned COUNT_MAX   = (64'd1 << COUNT_BITS_DEF) - 1;
  localparam longint unsigned PEAK_MAX    = 64'hFFFF;
  localparam int          RANDOM_BOOKINGS = 700;
  localparam int          MAX_REPORTS     = 10;

  class peak_scoreboard;
    longint unsigned  slot_load [SLOTS];
    longint unsigned  peak_now;
    logic [15:0]      expected_peaks [$];
    int               bookings;
    int               empties;
    int               clipped;
    int               checked;
    int               errors;

    function void note_booking(logic [IN_START_W-1:0] first_slot,
                               logic [IN_END_W-1:0] end_slot);
      int unsigned first;
      int unsigned stop;
      first = 32'(first_slot);
      stop  = (32'(end_slot) > SLOTS) ? SLOTS : 32'(end_slot);
      bookings++;
      if (32'(end_slot) > SLOTS) clipped++;
      if (first >= stop) begin
        empties++;
      end else begin
        for (int unsigned k = first; k < stop; k++) begin
          if (slot_load[k] < COUNT_MAX) slot_load[k]++;
          if (slot_load[k] > peak_now) peak_now = slot_load[k];
        end
      end
      expected_peaks.push_back((peak_now > PEAK_MAX) ? 16'hFFFF : 16'(peak_now));
    endfunction

    function void check_peak(logic [OUT_PEAK_W-1:0] got);
      logic [OUT_PEAK_W-1:0] want;
      if (expected_peaks.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: peak item %0d arrived with no booking pending", $realtime, got);
        return;
      end
      want = expected_peaks.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: peak_overlap mismatch: expected %0d, got %0d",
                   $realtime, want, got);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;
  bit                     quiet = 1'b0;
  peak_scoreboard         sb;

  interval_overlap_peak_tracker_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_booking(in_tdata[IN_START_W-1:0], in_tdata[IN_START_W +: IN_END_W]);
      if (out_tvalid && out_tready)
        sb.check_peak(out_tdata[OUT_PEAK_W-1:0]);
    end
  end

  initial begin
    int stall;
    forever begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // valid stays high across back-to-back items
  task automatic send_booking(input logic [IN_START_W-1:0] first_slot,
                              input logic [IN_END_W-1:0] end_slot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - IN_START_W - IN_END_W){1'b0}}, end_slot, first_slot};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    int                   pick;
    logic [IN_START_W-1:0] s;
    logic [IN_END_W-1:0]   e;

    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_booking(10'd0,    11'd1024);
    send_booking(10'd0,    11'd1);
    send_booking(10'd1023, 11'd1024);
    send_booking(10'd1023, 11'd2047);
    send_booking(10'd0,    11'd2047);
    send_booking(10'd512,  11'd512);
    send_booking(10'd700,  11'd300);
    send_booking(10'd1023, 11'd0);
    send_booking(10'd0,    11'd0);
    send_booking(10'd5,    11'd1025);
    send_booking(10'd511,  11'd513);
    send_booking(10'd1,    11'd1023);
    send_booking(10'd341,  11'd682);
    send_booking(10'd1020, 11'd1030);
    send_booking(10'd682,  11'd1365);
    send_booking(10'd1023, 11'd1023);
    send_booking(10'd0,    11'd1024);

    for (int n = 0; n < RANDOM_BOOKINGS; n++) begin
      quiet = (n % 200) >= 150;
      pick = $urandom_range(0, 99);
      s = IN_START_W'($urandom_range(0, SLOTS - 1));
      if (pick < 8) begin
        e = IN_END_W'($urandom_range(0, 32'(s)));
      end else if (pick < 16) begin
        e = IN_END_W'($urandom_range(SLOTS + 1, 2047));
      end else if (pick < 36) begin
        s = IN_START_W'($urandom_range(0, SLOTS / 2 - 1));
        e = IN_END_W'(32'(s) + $urandom_range(64, SLOTS - 32'(s)));
      end else if (pick < 70) begin
        // hot window pushes the peak up
        s = IN_START_W'($urandom_range(400, 460));
        e = IN_END_W'(32'(s) + $urandom_range(1, 40));
      end else begin
        e = IN_END_W'(32'(s) + $urandom_range(1, 32));
      end
      send_booking(s, e);
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.expected_peaks.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Booked %0d intervals (%0d empty, %0d with clipped end), checked %0d peaks,",
             sb.bookings, sb.empties, sb.clipped, sb.checked);
    $display("final peak occupancy %0d, %0d mismatches.", sb.peak_now, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
